// ===== hw/rtl/kmc_pkg.sv =====
package kmc_pkg;

   // Store sizes and coordinate width.
   localparam int MAX_POINTS   = 1024;
   localparam int MAX_CLUSTERS = 64;
   localparam int COORD_BITS   = 16;

   localparam int PT_AW  = $clog2(MAX_POINTS);
   localparam int CL_AW  = $clog2(MAX_CLUSTERS);
   localparam int PCNT_W = $clog2(MAX_POINTS + 1);
   localparam int K_W    = $clog2(MAX_CLUSTERS + 1);
   localparam int ITER_W = 8;
   localparam int SUM_W  = COORD_BITS + PCNT_W;
   localparam int DIST_W = 2 * COORD_BITS + 1;

   // Request function codes.
   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_RUN  = 2'd1;
   localparam logic [1:0] FUNC_CENT = 2'd2;
   localparam logic [1:0] FUNC_ASGN = 2'd3;

   // Response status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BAD_K = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_NUM_CLUSTERS = 1'b0;
   localparam logic CSR_MAX_ITER     = 1'b1;

   localparam logic [K_W-1:0]    NUM_CLUSTERS_RST = K_W'(8);
   localparam logic [ITER_W-1:0] MAX_ITER_RST     = ITER_W'(100);

   typedef struct packed {
      logic [1:0]                   func;
      logic signed [COORD_BITS-1:0] x_coord;
      logic signed [COORD_BITS-1:0] y_coord;
      logic [PT_AW-1:0]             item_index;
   } req_type;

   typedef struct packed {
      logic [1:0]                   status;
      logic signed [COORD_BITS-1:0] out_x;
      logic signed [COORD_BITS-1:0] out_y;
      logic [CL_AW-1:0]             cluster;
      logic [PCNT_W-1:0]            tally;
      logic                         converged;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } point_type;

endpackage

// ===== hw/rtl/kmeans_2d_clustering_core.sv =====
// Lloyd k-means engine over up to 1024 two-dimensional points. A load word
// stores one point, or reports a full store, and is answered directly; a
// centroid or assignment read is answered after a registered memory read.
// A run word copies the first k points as centroids, then each round
// clears the per-cluster sums, assigns each point with one shared
// squared-distance unit that visits centroids one at a time, and, unless
// nothing changed, recomputes each nonempty centroid with one bit-serial
// divider (two 27-step divisions per nonempty cluster). All state sits in
// synchronous memories with one write port and one read port, and one
// word is handled at a time.
module kmeans_2d_clustering_core
   import kmc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [7:0]  csr_wr_data
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_RESP_RD = 5'd1;
   localparam logic [4:0] S_INIT_RD = 5'd2;
   localparam logic [4:0] S_INIT_WR = 5'd3;
   localparam logic [4:0] S_CLR     = 5'd4;
   localparam logic [4:0] S_P_RD    = 5'd5;
   localparam logic [4:0] S_P_LAT   = 5'd6;
   localparam logic [4:0] S_C_RD    = 5'd7;
   localparam logic [4:0] S_C_DIF   = 5'd8;
   localparam logic [4:0] S_C_SQ    = 5'd9;
   localparam logic [4:0] S_C_CMP   = 5'd10;
   localparam logic [4:0] S_P_WB    = 5'd11;
   localparam logic [4:0] S_P_ACC   = 5'd12;
   localparam logic [4:0] S_U_RD    = 5'd13;
   localparam logic [4:0] S_U_LAT   = 5'd14;
   localparam logic [4:0] S_U_DX    = 5'd15;
   localparam logic [4:0] S_U_DY    = 5'd16;
   localparam logic [4:0] S_DONE    = 5'd17;

   // Memories.
   point_type                point_mem [MAX_POINTS];
   logic [CL_AW-1:0]         asgn_mem  [MAX_POINTS];
   point_type                cent_mem  [MAX_CLUSTERS];
   logic signed [SUM_W-1:0]  sumx_mem  [MAX_CLUSTERS];
   logic signed [SUM_W-1:0]  sumy_mem  [MAX_CLUSTERS];
   logic [PCNT_W-1:0]        cnt_mem   [MAX_CLUSTERS];

   point_type               pt_rd_ff;
   logic [CL_AW-1:0]        as_rd_ff;
   point_type               ce_rd_ff;
   logic signed [SUM_W-1:0] sx_rd_ff;
   logic signed [SUM_W-1:0] sy_rd_ff;
   logic [PCNT_W-1:0]       cn_rd_ff;

   // Control and datapath registers.
   logic [4:0]              state_ff;
   logic [K_W-1:0]          num_clusters_ff;
   logic [ITER_W-1:0]       max_iter_ff;
   logic [PCNT_W-1:0]       pl_ff;
   logic                    rv_ff;
   logic [K_W-1:0]          run_k_ff;
   logic [K_W-1:0]          k_ff;
   logic [ITER_W-1:0]       limit_ff;
   logic [ITER_W-1:0]       rounds_ff;
   logic                    first_ff;
   logic                    changed_ff;
   logic [CL_AW-1:0]        c_ff;
   logic [PT_AW-1:0]        i_ff;
   logic [1:0]              func_ff;
   point_type               px_ff;
   logic [CL_AW-1:0]        old_as_ff;
   logic [COORD_BITS-1:0]   dx_ff;
   logic [COORD_BITS-1:0]   dy_ff;
   logic [2*COORD_BITS-1:0] sqx_ff;
   logic [2*COORD_BITS-1:0] sqy_ff;
   logic [DIST_W-1:0]       best_d_ff;
   logic [CL_AW-1:0]        best_ff;
   logic signed [SUM_W-1:0] sy_hold_ff;
   logic [PCNT_W-1:0]       cnt_hold_ff;
   logic signed [COORD_BITS-1:0] qx_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic                    req_acc;
   logic                    rsp_load;
   logic [CL_AW-1:0]        c_last;
   logic [PT_AW-1:0]        i_last;
   logic signed [COORD_BITS:0] dfx;
   logic signed [COORD_BITS:0] dfy;
   logic [DIST_W-1:0]       dist_sum;
   logic [PT_AW-1:0]        pt_raddr;
   logic [PT_AW-1:0]        as_raddr;
   logic [CL_AW-1:0]        ce_raddr;
   logic [CL_AW-1:0]        sm_raddr;
   logic                    div_start;
   logic signed [SUM_W-1:0] div_num;
   logic [PCNT_W-1:0]       div_den;
   logic                    div_done;
   logic signed [COORD_BITS-1:0] div_q;
   logic                    sum_we;
   logic [CL_AW-1:0]        sum_waddr;
   logic signed [SUM_W-1:0] sumx_wd;
   logic signed [SUM_W-1:0] sumy_wd;
   logic [PCNT_W-1:0]       cnt_wd;
   logic                    cent_we;
   point_type               cent_wd;
   logic                    bad_k;
   logic                    idx_bad;

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign c_last = CL_AW'(k_ff - 1'b1);
   assign i_last = PT_AW'(pl_ff - 1'b1);

   assign bad_k = (num_clusters_ff == '0) || (num_clusters_ff > K_W'(MAX_CLUSTERS))
                  || (PCNT_W'(num_clusters_ff) > pl_ff);
   assign idx_bad = (req_data.func == FUNC_CENT)
                    ? (!rv_ff || (PCNT_W'(req_data.item_index) >= PCNT_W'(run_k_ff)))
                    : (!rv_ff || (PCNT_W'(req_data.item_index) >= pl_ff));

   // A response word is produced at once for loads and failed requests, and
   // at the end of a read or a run.
   assign rsp_load = (req_acc
                      && ((req_data.func == FUNC_LOAD)
                          || ((req_data.func == FUNC_RUN) && bad_k)
                          || (((req_data.func == FUNC_CENT) || (req_data.func == FUNC_ASGN))
                              && idx_bad)))
                     || (state_ff == S_RESP_RD) || (state_ff == S_DONE);

   // Squared distance pieces.
   assign dfx  = {px_ff.x[COORD_BITS-1], px_ff.x} - {ce_rd_ff.x[COORD_BITS-1], ce_rd_ff.x};
   assign dfy  = {px_ff.y[COORD_BITS-1], px_ff.y} - {ce_rd_ff.y[COORD_BITS-1], ce_rd_ff.y};
   assign dist_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   // Read address selection.
   assign pt_raddr = (state_ff == S_INIT_RD) ? PT_AW'(c_ff) : i_ff;
   assign as_raddr = (state_ff == S_IDLE) ? req_data.item_index : i_ff;
   assign ce_raddr = (state_ff == S_IDLE) ? req_data.item_index[CL_AW-1:0] : c_ff;
   assign sm_raddr = (state_ff == S_P_WB) ? best_ff : c_ff;

   // Sum store writes: cleared at round start, accumulated per point.
   always_comb begin
      sum_we    = 1'b0;
      sum_waddr = c_ff;
      sumx_wd   = '0;
      sumy_wd   = '0;
      cnt_wd    = '0;
      if (state_ff == S_CLR) begin
         sum_we = 1'b1;
      end else if (state_ff == S_P_ACC) begin
         sum_we    = 1'b1;
         sum_waddr = best_ff;
         sumx_wd   = sx_rd_ff + {{(SUM_W-COORD_BITS){px_ff.x[COORD_BITS-1]}}, px_ff.x};
         sumy_wd   = sy_rd_ff + {{(SUM_W-COORD_BITS){px_ff.y[COORD_BITS-1]}}, px_ff.y};
         cnt_wd    = cn_rd_ff + 1'b1;
      end
   end

   // Centroid store writes: seeding and mean update.
   always_comb begin
      cent_we = 1'b0;
      cent_wd = pt_rd_ff;
      if (state_ff == S_INIT_WR) begin
         cent_we = 1'b1;
      end else if ((state_ff == S_U_DY) && div_done) begin
         cent_we   = 1'b1;
         cent_wd.x = qx_ff;
         cent_wd.y = div_q;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && (req_data.func == FUNC_LOAD) && (pl_ff < PCNT_W'(MAX_POINTS))) begin
         point_mem[pl_ff[PT_AW-1:0]] <= '{x: req_data.x_coord, y: req_data.y_coord};
      end
      pt_rd_ff <= point_mem[pt_raddr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_P_WB) begin
         asgn_mem[i_ff] <= best_ff;
      end
      as_rd_ff <= asgn_mem[as_raddr];
   end

   always_ff @(posedge clock) begin
      if (cent_we) begin
         cent_mem[c_ff] <= cent_wd;
      end
      ce_rd_ff <= cent_mem[ce_raddr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sumx_mem[sum_waddr] <= sumx_wd;
         sumy_mem[sum_waddr] <= sumy_wd;
         cnt_mem[sum_waddr]  <= cnt_wd;
      end
      sx_rd_ff <= sumx_mem[sm_raddr];
      sy_rd_ff <= sumy_mem[sm_raddr];
      cn_rd_ff <= cnt_mem[sm_raddr];
   end

   // Shared divider for the centroid means.
   assign div_start = ((state_ff == S_U_LAT) && (cn_rd_ff != '0))
                      || ((state_ff == S_U_DX) && div_done);
   assign div_num   = (state_ff == S_U_LAT) ? sx_rd_ff : sy_hold_ff;
   assign div_den   = (state_ff == S_U_LAT) ? cn_rd_ff : cnt_hold_ff;

   kmc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_clusters_ff <= NUM_CLUSTERS_RST;
         max_iter_ff     <= MAX_ITER_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NUM_CLUSTERS: num_clusters_ff <= csr_wr_data[K_W-1:0];
            CSR_MAX_ITER:     max_iter_ff     <= csr_wr_data[ITER_W-1:0];
            default: ;
         endcase
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      if (state_ff == S_P_LAT) begin
         px_ff     <= pt_rd_ff;
         old_as_ff <= as_rd_ff;
      end
      if (state_ff == S_C_DIF) begin
         dx_ff <= dfx[COORD_BITS] ? COORD_BITS'(-dfx) : COORD_BITS'(dfx);
         dy_ff <= dfy[COORD_BITS] ? COORD_BITS'(-dfy) : COORD_BITS'(dfy);
      end
      if (state_ff == S_C_SQ) begin
         sqx_ff <= dx_ff * dx_ff;
         sqy_ff <= dy_ff * dy_ff;
      end
      if ((state_ff == S_C_CMP) && ((c_ff == '0) || (dist_sum < best_d_ff))) begin
         best_d_ff <= dist_sum;
         best_ff   <= c_ff;
      end
      if (state_ff == S_U_LAT) begin
         sy_hold_ff  <= sy_rd_ff;
         cnt_hold_ff <= cn_rd_ff;
      end
      if ((state_ff == S_U_DX) && div_done) begin
         qx_ff <= div_q;
      end
   end

   // Response valid: raised with a new word, dropped once it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Main sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pl_ff        <= '0;
         rv_ff        <= 1'b0;
         run_k_ff     <= '0;
         k_ff         <= '0;
         limit_ff     <= '0;
         rounds_ff    <= '0;
         first_ff     <= 1'b0;
         changed_ff   <= 1'b0;
         c_ff         <= '0;
         i_ff         <= '0;
         func_ff      <= FUNC_LOAD;
         rsp_ff       <= '0;
      end else begin
         unique case (state_ff) inside
            S_IDLE: begin
               if (req_acc) begin
                  func_ff <= req_data.func;
                  unique case (req_data.func) inside
                     FUNC_LOAD: begin
                        if (pl_ff >= PCNT_W'(MAX_POINTS)) begin
                           rsp_ff <= '{status: ST_FULL, tally: pl_ff, default: '0};
                        end else begin
                           pl_ff  <= pl_ff + 1'b1;
                           rv_ff  <= 1'b0;
                           rsp_ff <= '{status: ST_OK, tally: PCNT_W'(pl_ff + 1'b1),
                                       default: '0};
                        end
                     end
                     FUNC_RUN: begin
                        if (bad_k) begin
                           rv_ff  <= 1'b0;
                           rsp_ff <= '{status: ST_BAD_K, default: '0};
                        end else begin
                           rsp_ff     <= '0;
                           k_ff       <= num_clusters_ff;
                           limit_ff   <= (max_iter_ff == '0) ? ITER_W'(1) : max_iter_ff;
                           rounds_ff  <= '0;
                           first_ff   <= 1'b1;
                           c_ff       <= '0;
                           state_ff   <= S_INIT_RD;
                        end
                     end
                     FUNC_CENT, FUNC_ASGN: begin
                        if (idx_bad) begin
                           rsp_ff <= '{status: ST_RANGE, default: '0};
                        end else begin
                           state_ff <= S_RESP_RD;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_RESP_RD: begin
               if (func_ff == FUNC_CENT) begin
                  rsp_ff <= '{status: ST_OK, out_x: ce_rd_ff.x, out_y: ce_rd_ff.y,
                              default: '0};
               end else begin
                  rsp_ff <= '{status: ST_OK, cluster: as_rd_ff, default: '0};
               end
               state_ff <= S_IDLE;
            end
            S_INIT_RD: state_ff <= S_INIT_WR;
            S_INIT_WR: begin
               if (c_ff == c_last) begin
                  c_ff       <= '0;
                  rounds_ff  <= rounds_ff + 1'b1;
                  changed_ff <= 1'b0;
                  state_ff   <= S_CLR;
               end else begin
                  c_ff     <= c_ff + 1'b1;
                  state_ff <= S_INIT_RD;
               end
            end
            S_CLR: begin
               if (c_ff == c_last) begin
                  i_ff     <= '0;
                  state_ff <= S_P_RD;
               end else begin
                  c_ff <= c_ff + 1'b1;
               end
            end
            S_P_RD:  state_ff <= S_P_LAT;
            S_P_LAT: begin
               c_ff     <= '0;
               state_ff <= S_C_RD;
            end
            S_C_RD:  state_ff <= S_C_DIF;
            S_C_DIF: state_ff <= S_C_SQ;
            S_C_SQ:  state_ff <= S_C_CMP;
            S_C_CMP: begin
               if (c_ff == c_last) begin
                  state_ff <= S_P_WB;
               end else begin
                  c_ff     <= c_ff + 1'b1;
                  state_ff <= S_C_RD;
               end
            end
            S_P_WB: begin
               if (first_ff || (old_as_ff != best_ff)) begin
                  changed_ff <= 1'b1;
               end
               state_ff <= S_P_ACC;
            end
            S_P_ACC: begin
               if (i_ff == i_last) begin
                  first_ff <= 1'b0;
                  if (!changed_ff) begin
                     rsp_ff.converged <= 1'b1;
                     state_ff         <= S_DONE;
                  end else begin
                     c_ff     <= '0;
                     state_ff <= S_U_RD;
                  end
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_P_RD;
               end
            end
            S_U_RD:  state_ff <= S_U_LAT;
            S_U_LAT, S_U_DX, S_U_DY: begin
               // Move to the next cluster once this one is settled.
               if (((state_ff == S_U_LAT) && (cn_rd_ff == '0))
                   || ((state_ff == S_U_DY) && div_done)) begin
                  if (c_ff == c_last) begin
                     c_ff <= '0;
                     if (rounds_ff == limit_ff) begin
                        state_ff <= S_DONE;
                     end else begin
                        rounds_ff  <= rounds_ff + 1'b1;
                        changed_ff <= 1'b0;
                        state_ff   <= S_CLR;
                     end
                  end else begin
                     c_ff     <= c_ff + 1'b1;
                     state_ff <= S_U_RD;
                  end
               end else if (state_ff == S_U_LAT) begin
                  state_ff <= S_U_DX;
               end else if ((state_ff == S_U_DX) && div_done) begin
                  state_ff <= S_U_DY;
               end
            end
            S_DONE: begin
               rsp_ff   <= '{status: ST_OK, tally: PCNT_W'(rounds_ff),
                             converged: rsp_ff.converged, default: '0};
               rv_ff    <= 1'b1;
               run_k_ff <= k_ff;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // While a word is in progress no earlier response is still waiting.
   a_busy_rsp_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while a word is in progress");

   // The centroid walk never passes the cluster count of the run.
   a_cluster_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_C_CMP) |-> (K_W'(c_ff) < k_ff))
      else $error("centroid index beyond k");

   // Points are accumulated only from the loaded range.
   a_point_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_P_ACC) |-> (PCNT_W'(i_ff) < pl_ff))
      else $error("point index beyond loaded count");

   // The divider only finishes during a mean update.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == S_U_DX) || (state_ff == S_U_DY)))
      else $error("divider finished outside the update phase");

endmodule

// ===== hw/rtl/kmc_div.sv =====
module kmc_div
   import kmc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [SUM_W-1:0]      dividend,
   input  logic [PCNT_W-1:0]            divisor,
   output logic                         done,
   output logic signed [COORD_BITS-1:0] quotient
);

   localparam int DCW = $clog2(SUM_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic              neg_ff;
   logic [DCW-1:0]    cnt_ff;
   logic [PCNT_W-1:0] div_ff;
   logic [PCNT_W-1:0] rem_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [PCNT_W:0]   trial;
   logic              ge;

   // One restoring step per cycle on the magnitude of the dividend.
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign ge    = (trial >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= DCW'(SUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == DCW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[SUM_W-1];
         quo_ff <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? PCNT_W'(trial - {1'b0, div_ff}) : PCNT_W'(trial);
         quo_ff <= {quo_ff[SUM_W-2:0], ge};
      end
   end

   // The quotient is truncated toward zero, then given its sign back.
   assign done     = done_ff;
   assign quotient = neg_ff ? COORD_BITS'(-quo_ff) : COORD_BITS'(quo_ff);

endmodule

// ===== bench/tb_kmeans_2d_clustering_core.sv =====
`timescale 1ns / 100ps

import kmc_pkg::*;

// Predicts every response of the clustering core and checks the responses
// in order against the predictions.
class kmeans_scoreboard;
   int         pt_x[MAX_POINTS];
   int         pt_y[MAX_POINTS];
   int         asgn[MAX_POINTS];
   int         cen_x[MAX_CLUSTERS];
   int         cen_y[MAX_CLUSTERS];
   int         n_points;
   bit         results_ok;
   int         last_k;
   int         k_reg;
   int         iter_reg;
   int         errors;
   rsp_type    expected_q[$];

   function new();
      n_points   = 0;
      results_ok = 0;
      last_k     = 0;
      k_reg      = 8;
      iter_reg   = 100;
      errors     = 0;
   endfunction

   function void write_reg(logic idx, logic [7:0] value);
      if (idx == CSR_NUM_CLUSTERS)
         k_reg = int'(value[6:0]);
      else
         iter_reg = int'(value);
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // Index of the closest centroid; ties keep the lower index.
   function int closest(int px, int py, int k);
      longint unsigned best_d;
      longint unsigned d;
      longint          dx;
      longint          dy;
      int              best;
      best = 0;
      for (int c = 0; c < k; c++) begin
         dx = px - cen_x[c];
         dy = py - cen_y[c];
         d  = dx * dx + dy * dy;
         if (c == 0 || d < best_d) begin
            best_d = d;
            best   = c;
         end
      end
      return best;
   endfunction

   // Full Lloyd run; returns the number of rounds and sets the converged flag.
   function int cluster_points(int k, int limit, output bit conv);
      longint sx[MAX_CLUSTERS];
      longint sy[MAX_CLUSTERS];
      int     cnt[MAX_CLUSTERS];
      int     rounds;
      int     a;
      bit     changed;
      rounds = 0;
      conv   = 0;
      for (int c = 0; c < k; c++) begin
         cen_x[c] = pt_x[c];
         cen_y[c] = pt_y[c];
      end
      while (rounds < limit) begin
         changed = 0;
         rounds++;
         for (int i = 0; i < n_points; i++) begin
            a = closest(pt_x[i], pt_y[i], k);
            if (rounds == 1 || asgn[i] != a) begin
               asgn[i] = a;
               changed = 1;
            end
         end
         if (!changed) begin
            conv = 1;
            break;
         end
         for (int c = 0; c < k; c++) begin
            sx[c]  = 0;
            sy[c]  = 0;
            cnt[c] = 0;
         end
         for (int i = 0; i < n_points; i++) begin
            sx[asgn[i]] += pt_x[i];
            sy[asgn[i]] += pt_y[i];
            cnt[asgn[i]]++;
         end
         // Integer division truncates toward zero, as the core does.
         for (int c = 0; c < k; c++) begin
            if (cnt[c] > 0) begin
               cen_x[c] = int'(sx[c] / cnt[c]);
               cen_y[c] = int'(sy[c] / cnt[c]);
            end
         end
      end
      return rounds;
   endfunction

   function void note_request(req_type w);
      rsp_type e;
      bit      conv;
      int      idx;
      e   = '0;
      idx = int'(w.item_index);
      case (w.func)
         FUNC_LOAD: begin
            if (n_points >= MAX_POINTS) begin
               e.status = ST_FULL;
            end else begin
               pt_x[n_points] = int'(w.x_coord);
               pt_y[n_points] = int'(w.y_coord);
               n_points++;
               results_ok = 0;
            end
            e.tally = PCNT_W'(n_points);
         end
         FUNC_RUN: begin
            if (k_reg == 0 || k_reg > MAX_CLUSTERS || k_reg > n_points) begin
               e.status   = ST_BAD_K;
               results_ok = 0;
            end else begin
               e.tally     = PCNT_W'(cluster_points(k_reg, (iter_reg == 0) ? 1 : iter_reg,
                                                    conv));
               e.converged = conv;
               last_k      = k_reg;
               results_ok  = 1;
            end
         end
         FUNC_CENT: begin
            if (!results_ok || idx >= last_k) begin
               e.status = ST_RANGE;
            end else begin
               e.out_x = COORD_BITS'(cen_x[idx]);
               e.out_y = COORD_BITS'(cen_y[idx]);
            end
         end
         default: begin
            if (!results_ok || idx >= n_points)
               e.status = ST_RANGE;
            else
               e.cluster = CL_AW'(asgn[idx]);
         end
      endcase
      expected_q = {expected_q, e};
   endfunction

   function void compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   function void check_response(rsp_type a);
      rsp_type e;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected response, expected none, actual %h", $time, a);
         errors++;
         return;
      end
      e = expected_q.pop_front();
      compare_field("status", e.status, a.status);
      compare_field("out_x", e.out_x, a.out_x);
      compare_field("out_y", e.out_y, a.out_y);
      compare_field("cluster", e.cluster, a.cluster);
      compare_field("tally", e.tally, a.tally);
      compare_field("converged", e.converged, a.converged);
   endfunction
endclass

module tb_kmeans_2d_clustering_core;
   localparam int  RUN_BUDGET  = 20000;
   localparam int  CYCLE_LIMIT = 20000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = CSR_NUM_CLUSTERS;
   logic [7:0]  csr_wr_data = '0;

   kmeans_scoreboard sb = new();
   bit          calm = 1'b0;
   int          cycles = 0;
   int          items = 0;

   kmeans_2d_clustering_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // Run watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Response side: check accepted words and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_data);
      rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 19);
   end

   // Present one request word and hold it until it is taken.
   task automatic send_word(logic [1:0] fn, int x, int y, int idx);
      req_type w;
      w.func       = fn;
      w.x_coord    = COORD_BITS'(x);
      w.y_coord    = COORD_BITS'(y);
      w.item_index = PT_AW'(idx);
      if (!calm) begin
         while ($urandom_range(0, 99) < 19) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_request(w);
      items++;
   endtask

   // Stop sending until every outstanding response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // Both registers are written back to back while the core is idle.
   task automatic write_config(int k, int iter);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_NUM_CLUSTERS;
      csr_wr_data <= 8'(k);
      @(posedge clock);
      sb.write_reg(CSR_NUM_CLUSTERS, 8'(k));
      csr_index   <= CSR_MAX_ITER;
      csr_wr_data <= 8'(iter);
      @(posedge clock);
      sb.write_reg(CSR_MAX_ITER, 8'(iter));
      csr_wr_en   <= 1'b0;
   endtask

   function automatic int clip(int v);
      if (v > 32767)
         return 32767;
      if (v < -32768)
         return -32768;
      return v;
   endfunction

   // Loads a point near one of a few centers, or anywhere now and then.
   task automatic load_point(int ncent, int cx[4], int cy[4], int spread);
      int c;
      c = $urandom_range(0, ncent - 1);
      if ($urandom_range(0, 9) == 0)
         send_word(FUNC_LOAD, $urandom_range(0, 65535) - 32768,
                   $urandom_range(0, 65535) - 32768, $urandom_range(0, 1023));
      else
         send_word(FUNC_LOAD,
                   clip(cx[c] + $urandom_range(0, 2 * spread) - spread),
                   clip(cy[c] + $urandom_range(0, 2 * spread) - spread),
                   $urandom_range(0, 1023));
   endtask

   // One read of a centroid or an assignment, usually in range.
   task automatic random_read();
      logic [1:0] fn;
      int         bound;
      int         idx;
      fn    = $urandom_range(0, 1) ? FUNC_CENT : FUNC_ASGN;
      bound = (fn == FUNC_CENT) ? sb.last_k : sb.n_points;
      if (bound > 0 && $urandom_range(0, 3) != 0)
         idx = $urandom_range(0, bound - 1);
      else
         idx = $urandom_range(0, 1023);
      send_word(fn, $urandom_range(0, 65535) - 32768,
                $urandom_range(0, 65535) - 32768, idx);
   endtask

   initial begin
      int cx[4];
      int cy[4];
      int n_after;
      int nload;
      int k;
      int kcap;
      int iter;
      int cost;
      int ncent;
      int spread;
      int phase;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reads before any run, and a run with an empty store.
      send_word(FUNC_CENT, 0, 0, 0);
      send_word(FUNC_ASGN, 0, 0, 0);
      send_word(FUNC_ASGN, -1, -1, 1023);
      send_word(FUNC_RUN, 0, 0, 0);

      // Corner coordinates; with k equal to the point count the run
      // converges in the second round.
      send_word(FUNC_LOAD, -32768, -32768, 1023);
      send_word(FUNC_LOAD, 32767, 32767, 0);
      send_word(FUNC_LOAD, 0, 0, 512);
      send_word(FUNC_LOAD, -32768, 32767, 5);
      send_word(FUNC_LOAD, 32767, -32768, 7);
      send_word(FUNC_LOAD, 1, -1, 3);
      send_word(FUNC_LOAD, -1, 1, 9);
      send_word(FUNC_LOAD, 1, -1, 100);
      send_word(FUNC_RUN, 0, 0, 0);
      send_word(FUNC_CENT, 0, 0, 0);
      send_word(FUNC_CENT, 0, 0, 7);
      send_word(FUNC_CENT, 0, 0, 8);
      send_word(FUNC_CENT, 0, 0, 63);
      send_word(FUNC_ASGN, 0, 0, 7);
      send_word(FUNC_ASGN, 0, 0, 8);
      send_word(FUNC_ASGN, 0, 0, 1023);

      // Random phases, each with its own configuration, until the store
      // is nearly full.
      phase = 0;
      while (sb.n_points < 990) begin
         drain();
         calm = (phase == 4);
         nload = (phase == 0) ? 64 - sb.n_points : $urandom_range(15, 45);
         if (sb.n_points + nload > 1000)
            nload = 1000 - sb.n_points;
         n_after = sb.n_points + nload;

         // Keep every run short enough, however many rounds it takes.
         kcap = 5000 / n_after - 1;
         if (kcap < 1)
            kcap = 1;
         if (kcap > n_after)
            kcap = n_after;
         if (kcap > MAX_CLUSTERS)
            kcap = MAX_CLUSTERS;
         if (phase == 0)
            k = MAX_CLUSTERS;
         else if ($urandom_range(0, 3) == 0)
            k = kcap;
         else
            k = $urandom_range(1, kcap);
         cost = n_after * (4 + 4 * k) + 63 * k;
         iter = RUN_BUDGET / cost;
         if (iter < 1)
            iter = 1;
         if (iter > 255)
            iter = 255;
         if (k == 1 && $urandom_range(0, 2) == 0)
            iter = 255;
         if ($urandom_range(0, 7) == 0)
            iter = 0;
         // An invalid cluster count now and then.
         if (phase != 0 && $urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
               0: k = 0;
               1: k = (n_after < 127) ? n_after + 1 : 127;
               default: k = $urandom_range(65, 127);
            endcase
         end
         write_config(k, iter);

         ncent  = $urandom_range(1, 4);
         spread = 1 << $urandom_range(2, 12);
         for (int c = 0; c < 4; c++) begin
            cx[c] = $urandom_range(0, 65535) - 32768;
            cy[c] = $urandom_range(0, 65535) - 32768;
         end
         for (int i = 0; i < nload; i++)
            load_point(ncent, cx, cy, spread);
         send_word(FUNC_RUN, 0, 0, $urandom_range(0, 1023));

         for (int i = $urandom_range(18, 32); i > 0; i--) begin
            case ($urandom_range(0, 14))
               0: if (sb.n_points < 1000) load_point(ncent, cx, cy, spread);
               1: send_word(FUNC_RUN, 0, 0, $urandom_range(0, 1023));
               default: random_read();
            endcase
         end
         phase++;
      end

      // Fill the store, then overflow it.
      drain();
      calm = 1'b0;
      write_config(1, 1);
      while (sb.n_points < MAX_POINTS)
         send_word(FUNC_LOAD, $urandom_range(0, 65535) - 32768,
                   $urandom_range(0, 65535) - 32768, $urandom_range(0, 1023));
      for (int i = 0; i < 3; i++)
         send_word(FUNC_LOAD, 100, -100, $urandom_range(0, 1023));
      send_word(FUNC_RUN, 0, 0, 0);
      send_word(FUNC_ASGN, 0, 0, 1023);
      send_word(FUNC_CENT, 0, 0, 0);
      send_word(FUNC_CENT, 0, 0, 1);
      for (int i = 0; i < 10; i++)
         random_read();

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/kmc_pkg.sv
hw/rtl/kmc_div.sv
hw/rtl/kmeans_2d_clustering_core.sv
bench/tb_kmeans_2d_clustering_core.sv
